// ===== hdl/rectangle_zone_hit_test_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Rectangle zone hit test unit: assertion macros
// Shared property forms for the checks at the end of the RTL modules.
// ---------------------------------------------------------------------------
`ifndef RECTANGLE_ZONE_HIT_TEST_UNIT_DEFINES_SVH
`define RECTANGLE_ZONE_HIT_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define RZHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define RZHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rzht_pkg.sv =====
// ---------------------------------------------------------------------------
// Rectangle zone hit test package
// Widths, request codes, state encoding and record types for the hit tester.
// ---------------------------------------------------------------------------
package rzht_pkg;

   localparam int unsigned MAX_ZONES_DEF = 64;

   localparam int unsigned COORD_W   = 16;
   localparam int unsigned KIND_W    = 4;
   localparam int unsigned TAG_W     = 16;
   localparam int unsigned LOCAL_W   = 15;
   localparam int unsigned ACTION_W  = 2;

   localparam int unsigned ZONE_W     = 4 * COORD_W + KIND_W + TAG_W;
   localparam int unsigned REQ_DATA_W = ((ZONE_W + 7) / 8) * 8;
   localparam int unsigned RESULT_W   = 2 + KIND_W + TAG_W + 2 * LOCAL_W;
   localparam int unsigned RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_TEST  = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_PUSH = 4'b1000
   } state_type;

   // Field order matches the request tdata, lowest bits last in the list
   typedef struct packed {
      logic [TAG_W-1:0]          tag;
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] height;
      logic signed [COORD_W-1:0] width;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] left;
   } rect_type;

   typedef struct packed {
      logic [LOCAL_W-1:0] local_y;
      logic [LOCAL_W-1:0] local_x;
      logic [TAG_W-1:0]   hit_tag;
      logic [KIND_W-1:0]  hit_kind;
      logic               hit;
      logic               accepted;
   } result_type;

endpackage

// ===== hdl/rectangle_zone_hit_test_unit.sv =====
// ---------------------------------------------------------------------------
// Rectangle zone hit test unit
// Zone table in a single-port memory, scanned in insertion order by one
// bound-compare unit; first zone holding the point wins.
// ---------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser: action; tdata: pos_x, pos_y, size_w, size_h, kind_in, tag_in
//  rsp_    | out       | tdata: accepted, hit, hit_kind, hit_tag, local_x, local_y
//
// Clear, add and unused actions pass from acceptance through the execute and push states to the result.
// A test scans the N stored zones in order, one zone read from the table memory
// and compared per cycle; it stops at the first hit.
// Reset clears the zone count and the control state; the table memory is not cleared.
// The result register holds while rsp_tready is low; the next request is
// accepted once the previous one has been handed to it.
// ---------------------------------------------------------------------------
module rectangle_zone_hit_test_unit #(
   parameter int unsigned MAX_ZONES = rzht_pkg::MAX_ZONES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] action
   input  logic [rzht_pkg::ACTION_W-1:0]    req_tuser,
   // [15:0] pos_x, [31:16] pos_y, [47:32] size_w, [63:48] size_h,
   // [67:64] kind_in, [83:68] tag_in, [87:84] zero
   input  logic [rzht_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] accepted, [1] hit, [5:2] hit_kind, [21:6] hit_tag,
   // [36:22] local_x, [51:37] local_y, [55:52] zero
   output logic [rzht_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rzht_pkg::*;

   `include "rectangle_zone_hit_test_unit_defines.svh"

   localparam int unsigned CNT_W = $clog2(MAX_ZONES + 1);
   localparam int unsigned IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

   state_type          state_ff, state_in;
   logic [ACTION_W-1:0] action_ff;
   rect_type           req_zone_ff;
   logic [CNT_W-1:0]   entry_cnt_ff, entry_cnt_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               rd_vld_ff, rd_vld_in;
   rect_type           rd_zone_ff;
   result_type         res_ff, res_in;
   result_type         rsp_ff;
   logic               rsp_vld_ff, rsp_vld_in;

   rect_type           zone_mem [MAX_ZONES];

   logic               mem_we;
   logic               rd_en;
   logic               req_fire;
   logic               rsp_free;
   logic               table_full;

   // Bound compare unit, shared by every zone of a scan
   logic signed [COORD_W:0] pt_x, pt_y;
   logic signed [COORD_W:0] lo_x, lo_y, hi_x, hi_y;
   logic [COORD_W-1:0]      dx, dy;
   logic                    zone_hit;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign table_full = (entry_cnt_ff >= CNT_W'(MAX_ZONES));
   assign rd_en      = (state_ff == ST_SCAN) && (issue_ff < entry_cnt_ff);
   assign mem_we     = (state_ff == ST_EXEC) && (action_ff == ACT_ADD) && !table_full;

   assign pt_x = {req_zone_ff.left[COORD_W-1], req_zone_ff.left};
   assign pt_y = {req_zone_ff.top[COORD_W-1],  req_zone_ff.top};
   assign lo_x = {rd_zone_ff.left[COORD_W-1],  rd_zone_ff.left};
   assign lo_y = {rd_zone_ff.top[COORD_W-1],   rd_zone_ff.top};
   assign hi_x = lo_x + {rd_zone_ff.width[COORD_W-1],  rd_zone_ff.width};
   assign hi_y = lo_y + {rd_zone_ff.height[COORD_W-1], rd_zone_ff.height};
   assign dx   = req_zone_ff.left - rd_zone_ff.left;
   assign dy   = req_zone_ff.top  - rd_zone_ff.top;
   assign zone_hit = rd_vld_ff && (pt_x >= lo_x) && (pt_x < hi_x)
                     && (pt_y >= lo_y) && (pt_y < hi_y);

   always_comb begin
      state_in      = state_ff;
      entry_cnt_in  = entry_cnt_ff;
      issue_in      = issue_ff;
      rd_vld_in     = rd_en;
      res_in        = res_ff;
      rsp_vld_in    = rsp_vld_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            issue_in = '0;
            state_in = ST_PUSH;
            case (action_ff)
               ACT_CLEAR: begin
                  entry_cnt_in    = '0;
                  res_in.accepted = 1'b1;
               end
               ACT_ADD: begin
                  if (!table_full) begin
                     entry_cnt_in    = entry_cnt_ff + CNT_W'(1);
                     res_in.accepted = 1'b1;
                  end
               end
               ACT_TEST: begin
                  state_in = ST_SCAN;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (zone_hit) begin
               // stop on the first match; a read still in flight is dropped
               res_in.hit      = 1'b1;
               res_in.hit_kind = rd_zone_ff.kind;
               res_in.hit_tag  = rd_zone_ff.tag;
               res_in.local_x  = dx[LOCAL_W-1:0];
               res_in.local_y  = dy[LOCAL_W-1:0];
               state_in        = ST_PUSH;
            end else if (!rd_en && !rd_vld_ff) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         entry_cnt_ff  <= '0;
         issue_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entry_cnt_ff  <= entry_cnt_in;
         issue_ff      <= issue_in;
         rd_vld_ff     <= rd_vld_in && (state_in == ST_SCAN);
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff   <= req_tuser;
         req_zone_ff <= rect_type'(req_tdata[ZONE_W-1:0]);
      end
      res_ff <= res_in;
      if (state_ff == ST_PUSH && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   // Zone table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         zone_mem[entry_cnt_ff[IDX_W-1:0]] <= req_zone_ff;
      end
      if (rd_en) begin
         rd_zone_ff <= zone_mem[issue_ff[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RESULT_W){1'b0}}, rsp_ff};

   `RZHT_ASSERT_NEXT(a_req_starts_exec, clock, reset, req_fire,
      state_ff == ST_EXEC, "request accepted without entering execution")
   `RZHT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      entry_cnt_ff <= CNT_W'(MAX_ZONES), "zone count beyond table depth")
   `RZHT_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == ST_SCAN,
      issue_ff <= entry_cnt_ff, "scan ran past the last zone")
   `RZHT_ASSERT_NEXT(a_push_lands, clock, reset, state_ff == ST_PUSH && rsp_free,
      rsp_vld_ff && state_ff == ST_IDLE, "result not handed to output register")
   `RZHT_ASSERT_NOW(a_hit_xor_acc, clock, reset, rsp_vld_ff,
      !(rsp_ff.hit && rsp_ff.accepted), "result flags both hit and accepted")

endmodule
